[sv/mpsp_pkg.sv]
// shared types and constants for the minimum-penalty stop planner
// no dependencies; used by every module of the block
package mpsp_pkg;

    localparam int STOP_W        = 16;
    localparam int PEN_W         = 22;
    localparam int MAX_STOPS_DEF = 32;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [PEN_W-1:0]  PENALTY_MAX  = 22'h3FFFFF;
    localparam logic [STOP_W-1:0] TARGET_RESET = 16'd200;

    // one request on the input channel
    typedef struct packed {
        logic [STOP_W-1:0] position_km;
        logic              last_item;
    } item_t;

    // one result on the result channel
    typedef struct packed {
        logic [STOP_W-1:0] stop_km;
        logic [PEN_W-1:0]  min_penalty;
        logic              is_final;
        logic              overflow;
    } result_t;

    // classified item handed from front to back
    typedef struct packed {
        logic [STOP_W-1:0] pos;
        logic              last;
        logic              store;
        logic              ovf;
    } job_t;

endpackage

[sv/mpsp_front.sv]
// front end: accepts stop requests and classifies them as stored or dropped
// depends on mpsp_pkg
module mpsp_front #(
    parameter int MAX_STOPS = mpsp_pkg::MAX_STOPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  mpsp_pkg::item_t     item,
    output logic                push_valid,
    input  logic                push_ready,
    output mpsp_pkg::job_t      push_data
);

    localparam int CNT_W = $clog2(MAX_STOPS + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             store;
    logic             accept;

    // classify against the run's fill count
    assign store      = count_reg < CNT_W'(MAX_STOPS);
    assign item_ready = push_ready;
    assign push_valid = item_valid;
    assign accept     = item_valid && push_ready;

    always_comb
    begin
        push_data.pos   = item.position_km;
        push_data.last  = item.last_item;
        push_data.store = store;
        push_data.ovf   = ovf_reg | ~store;
    end

    // run bookkeeping, cleared by the last request of a run
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            if (item.last_item)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                count_next = count_reg + CNT_W'(store);
                ovf_next   = ovf_reg | ~store;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

[sv/mpsp_queue.sv]
// short fifo of classified requests between front and back
// depends on mpsp_pkg
module mpsp_queue #(
    parameter int DEPTH = mpsp_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  mpsp_pkg::job_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output mpsp_pkg::job_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mpsp_pkg::job_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push, do_pop;

    assign push_ready = fill_reg != CNT_W'(DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   fill_next = fill_reg + CNT_W'(1);
            2'b01:   fill_next = fill_reg - CNT_W'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[sv/mpsp_back.sv]
// back end: cost scan over stored stops, predecessor traceback and result register
// depends on mpsp_pkg
module mpsp_back #(
    parameter int MAX_STOPS = mpsp_pkg::MAX_STOPS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [mpsp_pkg::STOP_W-1:0] target_length,
    input  logic                        pop_valid,
    output logic                        pop_ready,
    input  mpsp_pkg::job_t              pop_data,
    output logic                        result_valid,
    input  logic                        result_ready,
    output mpsp_pkg::result_t           result
);

    localparam int CNT_W = $clog2(MAX_STOPS + 1);
    localparam int IDX_W = $clog2(MAX_STOPS);
    localparam int SW    = mpsp_pkg::STOP_W;
    localparam int PW    = mpsp_pkg::PEN_W;
    localparam int LEG_W = SW + 3;
    localparam int MAG_W = SW + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TB_PRED,
        ST_TB_CHECK,
        ST_TB_POS,
        ST_TB_EMIT,
        ST_TB_FINAL
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic              last_reg, last_next;
    logic              ovf_reg, ovf_next;
    logic [SW-1:0]     cur_pos_reg, cur_pos_next;
    logic [PW-1:0]     best_reg, best_next;
    logic [IDX_W-1:0]  pick_reg, pick_next;
    logic              out_valid_reg, out_valid_next;
    mpsp_pkg::result_t out_data_reg, out_data_next;
    logic              v1_reg, v1_next;
    logic              v2_reg, v3_reg;

    // storage
    logic [SW-1:0]     pos_mem  [MAX_STOPS];
    logic [PW-1:0]     cost_mem [MAX_STOPS];
    logic [IDX_W-1:0]  pred_mem [MAX_STOPS];
    logic [SW-1:0]     pos_rd_reg;
    logic [PW-1:0]     cost_rd_reg;
    logic [IDX_W-1:0]  pred_rd_reg;

    // scan pipeline data
    logic [IDX_W-1:0]        j1_reg, j2_reg, j3_reg;
    logic signed [LEG_W-1:0] e2_reg;
    logic [PW-1:0]           cost2_reg;
    logic [PW-1:0]           sum3_reg;

    logic signed [LEG_W-1:0] e_calc;
    logic [MAG_W-1:0]        mag;
    logic [PW:0]             sum_wide;
    logic [PW-1:0]           sum_sat;
    logic                    take;
    logic [PW-1:0]           best_new;
    logic [IDX_W-1:0]        pick_new;
    logic [CNT_W-1:0]        n_dec;
    logic                    out_free;
    logic                    issue;
    logic                    pos_we, cost_we, pred_we;
    logic [IDX_W-1:0]        waddr;
    logic [SW-1:0]           pos_wdata;
    logic [PW-1:0]           cost_wdata;
    logic [IDX_W-1:0]        pred_wdata;
    logic [IDX_W-1:0]        pos_raddr, cost_raddr;

    assign pop_ready    = state_reg == ST_IDLE;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;
    assign out_free     = !out_valid_reg || result_ready;
    assign n_dec        = n_reg - CNT_W'(1);
    assign issue        = (state_reg == ST_SCAN) && (j_reg < i_reg);

    // leg penalty: target minus signed distance, then magnitude and saturating sum
    assign e_calc   = $signed({3'b000, target_length}) + $signed({3'b000, pos_rd_reg})
                    - $signed({3'b000, cur_pos_reg});
    assign mag      = e2_reg[LEG_W-1] ? MAG_W'(-e2_reg) : e2_reg[MAG_W-1:0];
    assign sum_wide = {1'b0, cost2_reg} + {{(PW + 1 - MAG_W){1'b0}}, mag};
    assign sum_sat  = (sum_wide > {1'b0, mpsp_pkg::PENALTY_MAX}) ? mpsp_pkg::PENALTY_MAX
                                                                 : sum_wide[PW-1:0];

    // running minimum, earliest index wins on a tie
    assign take     = (j3_reg == '0) || (sum3_reg < best_reg);
    assign best_new = take ? sum3_reg : best_reg;
    assign pick_new = take ? j3_reg : pick_reg;

    // memory read addresses
    assign pos_raddr  = (state_reg == ST_SCAN) ? j_reg[IDX_W-1:0] : cur_reg;
    assign cost_raddr = (state_reg == ST_SCAN) ? j_reg[IDX_W-1:0] : tail_reg;
    assign waddr      = (state_reg == ST_SCAN) ? i_reg[IDX_W-1:0] : n_reg[IDX_W-1:0];

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cur_next       = cur_reg;
        tail_next      = tail_reg;
        last_next      = last_reg;
        ovf_next       = ovf_reg;
        cur_pos_next   = cur_pos_reg;
        best_next      = best_reg;
        pick_next      = pick_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_data_next  = out_data_reg;
        v1_next        = issue;
        pos_we         = 1'b0;
        cost_we        = 1'b0;
        pred_we        = 1'b0;
        pos_wdata      = pop_data.pos;
        cost_wdata     = '0;
        pred_wdata     = '0;

        if (issue)
        begin
            j_next = j_reg + CNT_W'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    last_next = pop_data.last;
                    ovf_next  = pop_data.ovf;
                    if (pop_data.store)
                    begin
                        pos_we       = 1'b1;
                        cur_pos_next = pop_data.pos;
                        i_next       = n_reg;
                        n_next       = n_reg + CNT_W'(1);
                        if (n_reg == '0)
                        begin
                            // start of a run: zero cost, its own predecessor
                            cost_we = 1'b1;
                            pred_we = 1'b1;
                            if (pop_data.last)
                            begin
                                cur_next   = n_reg[IDX_W-1:0];
                                tail_next  = n_reg[IDX_W-1:0];
                                state_next = ST_TB_PRED;
                            end
                        end
                        else
                        begin
                            j_next     = '0;
                            state_next = ST_SCAN;
                        end
                    end
                    else if (pop_data.last)
                    begin
                        cur_next   = n_dec[IDX_W-1:0];
                        tail_next  = n_dec[IDX_W-1:0];
                        state_next = ST_TB_PRED;
                    end
                end
            end

            ST_SCAN:
            begin
                if (v3_reg)
                begin
                    best_next = best_new;
                    pick_next = pick_new;
                    if (CNT_W'(j3_reg) == i_reg - CNT_W'(1))
                    begin
                        cost_we    = 1'b1;
                        pred_we    = 1'b1;
                        cost_wdata = best_new;
                        pred_wdata = pick_new;
                        if (last_reg)
                        begin
                            cur_next   = i_reg[IDX_W-1:0];
                            tail_next  = i_reg[IDX_W-1:0];
                            state_next = ST_TB_PRED;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            ST_TB_PRED:
            begin
                state_next = ST_TB_CHECK;
            end

            ST_TB_CHECK:
            begin
                if (pred_rd_reg == cur_reg)
                begin
                    state_next = ST_TB_FINAL;
                end
                else
                begin
                    cur_next   = pred_rd_reg;
                    state_next = ST_TB_POS;
                end
            end

            ST_TB_POS:
            begin
                state_next = ST_TB_EMIT;
            end

            ST_TB_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.stop_km     = pos_rd_reg;
                    out_data_next.min_penalty = '0;
                    out_data_next.is_final    = 1'b0;
                    out_data_next.overflow    = ovf_reg;
                    state_next                = ST_TB_PRED;
                end
            end

            ST_TB_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.stop_km     = '0;
                    out_data_next.min_penalty = cost_rd_reg;
                    out_data_next.is_final    = 1'b1;
                    out_data_next.overflow    = ovf_reg;
                    n_next                    = '0;
                    state_next                = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            cur_reg       <= '0;
            tail_reg      <= '0;
            last_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            cur_pos_reg   <= '0;
            best_reg      <= '0;
            pick_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            cur_reg       <= cur_next;
            tail_reg      <= tail_next;
            last_reg      <= last_next;
            ovf_reg       <= ovf_next;
            cur_pos_reg   <= cur_pos_next;
            best_reg      <= best_next;
            pick_reg      <= pick_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            v1_reg        <= v1_next;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
        end
    end

    // memories with registered reads
    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[waddr] <= pos_wdata;
        end
        if (cost_we)
        begin
            cost_mem[waddr] <= cost_wdata;
        end
        if (pred_we)
        begin
            pred_mem[waddr] <= pred_wdata;
        end
        pos_rd_reg  <= pos_mem[pos_raddr];
        cost_rd_reg <= cost_mem[cost_raddr];
        pred_rd_reg <= pred_mem[cur_reg];
    end

    // scan pipeline: read, leg error, saturating sum
    always_ff @(posedge clk)
    begin
        j1_reg    <= j_reg[IDX_W-1:0];
        j2_reg    <= j1_reg;
        e2_reg    <= e_calc;
        cost2_reg <= cost_rd_reg;
        j3_reg    <= j2_reg;
        sum3_reg  <= sum_sat;
    end

    // stored count stays within capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CNT_W'(MAX_STOPS))
        else $error("stop count beyond capacity");

    // predecessors of every stop but the first point to an earlier stop
    a_pred_back: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TB_CHECK) && (cur_reg != '0) |-> pred_rd_reg < cur_reg)
        else $error("predecessor does not point backward");

    // scan results only arrive while scanning
    a_scan_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> state_reg == ST_SCAN)
        else $error("scan pipeline active outside scan");

    // the penalty result closes the run
    a_run_close: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TB_FINAL) && out_free |=> (n_reg == '0) && out_data_reg.is_final)
        else $error("run not closed after penalty result");

endmodule

[sv/min_penalty_stop_planner.sv]
// a stored stop after the first, with i earlier stops, holds the back end while it scans
// all i earlier stops, one read per cycle over the stop memories; the first stop of a run
// is stored without a scan
// traceback after the last request: a result per traced stop, then the penalty result
// requests are queued while the back end scans or traces back
// reset: all control cleared, target_length back to 200; stop memories are not cleared
module min_penalty_stop_planner #(
    parameter int MAX_STOPS = mpsp_pkg::MAX_STOPS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [mpsp_pkg::STOP_W-1:0] cfg_wr_data,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  mpsp_pkg::item_t             item,
    output logic                        result_valid,
    input  logic                        result_ready,
    output mpsp_pkg::result_t           result
);

    logic [mpsp_pkg::STOP_W-1:0] target_reg, target_next;
    logic                        push_valid, push_ready;
    mpsp_pkg::job_t              push_data;
    logic                        pop_valid, pop_ready;
    mpsp_pkg::job_t              pop_data;

    // target length register
    assign target_next = cfg_wr_en ? cfg_wr_data : target_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= mpsp_pkg::TARGET_RESET;
        end
        else
        begin
            target_reg <= target_next;
        end
    end

    // request classification
    mpsp_front #(
        .MAX_STOPS (MAX_STOPS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // decoupling queue
    mpsp_queue #(
        .DEPTH (mpsp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // cost scan and traceback
    mpsp_back #(
        .MAX_STOPS (MAX_STOPS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .target_length (target_reg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_data      (pop_data),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result)
    );

endmodule
